FILE: rtl/core/rbpto_pkg.sv
`timescale 1ns / 1ps

package rbpto_pkg;

    localparam int MODE_W     = 16;
    localparam int MASK_W     = 8;
    localparam int NUM_W      = 4;
    localparam int PCT_W      = 8;
    localparam int DELAY_W    = 16;
    localparam int PHASE_W    = 4;
    localparam int LEVEL_W    = 5;
    localparam int ACTION_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int SLOT_LIMIT = 16;

    localparam logic [ACTION_W-1:0] ACT_ON      = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_OFF     = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_POWER   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_DELAYED = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_TENTH   = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_MS      = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_DEFAULT = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_ON_LEVEL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_ON = 2'd1;

    localparam logic [MODE_W-1:0]  MODE_OFF     = 16'd0;
    localparam logic [MODE_W-1:0]  MODE_ON      = 16'd1;
    localparam logic [MODE_W-1:0]  PWM_BASE     = 16'd10;
    localparam logic [MODE_W-1:0]  TIMED_BASE   = 16'd20;
    localparam logic [MODE_W-1:0]  DELAY_OFFSET = 16'd19;
    localparam logic [DELAY_W-1:0] DELAY_MAX    = 16'd36000;
    localparam logic [PHASE_W-1:0] PHASE_LAST   = 4'd9;
    localparam logic [LEVEL_W-1:0] LEVEL_PWM_MAX = 5'd9;
    localparam logic [LEVEL_W-1:0] LEVEL_FULL    = 5'd10;

    localparam logic [PCT_W:0] ROUND_BIAS  = 9'd5;
    localparam int             RECIP_MUL   = 205;
    localparam int             RECIP_SHIFT = 11;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [NUM_W-1:0]    relay_number;
        logic [PCT_W-1:0]    power_percent;
        logic [DELAY_W-1:0]  delay_tenths;
    } cmd_t;

    typedef struct packed {
        logic [MASK_W-1:0] pin_levels;
        logic [MASK_W-1:0] on_mask;
        logic [MASK_W-1:0] delayed_off_mask;
    } res_t;

    typedef struct packed {
        logic                valid;
        logic [ACTION_W-1:0] action;
        logic                hit;
        logic [NUM_W-1:0]    sel;
        logic [LEVEL_W-1:0]  level;
        logic                delay_ok;
        logic [DELAY_W-1:0]  delay;
        logic [PHASE_W-1:0]  phase;
        res_t                acc;
    } token_t;

endpackage

FILE: rtl/core/rbpto_cell.sv
`timescale 1ns / 1ps

module rbpto_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rbpto_pkg::token_t   tok_in,
    input  logic                def_on,
    input  logic                on_level,
    output rbpto_pkg::token_t   tok_out
);

    logic [rbpto_pkg::MODE_W-1:0] mode_reg;
    logic [rbpto_pkg::MODE_W-1:0] mode_next;
    logic                         active_reg;
    logic                         active_next;
    rbpto_pkg::token_t            tok_reg;
    rbpto_pkg::token_t            tok_next;
    logic                         hit;
    logic                         pin;
    logic                         is_on;
    logic                         is_timed;
    logic [rbpto_pkg::MODE_W-1:0] pwm_offset;

    assign hit        = tok_in.hit && (tok_in.sel == rbpto_pkg::NUM_W'(CELL_IDX));
    assign pwm_offset = mode_reg - rbpto_pkg::PWM_BASE;

    always_comb
    begin
        mode_next   = mode_reg;
        active_next = active_reg;
        if (tok_in.valid)
        begin
            case (tok_in.action)
                rbpto_pkg::ACT_ON:
                begin
                    if (hit)
                    begin
                        mode_next   = rbpto_pkg::MODE_ON;
                        active_next = 1'b1;
                    end
                end
                rbpto_pkg::ACT_OFF:
                begin
                    if (hit)
                    begin
                        mode_next   = rbpto_pkg::MODE_OFF;
                        active_next = 1'b0;
                    end
                end
                rbpto_pkg::ACT_POWER:
                begin
                    if (hit)
                    begin
                        if (tok_in.level == '0)
                        begin
                            mode_next   = rbpto_pkg::MODE_OFF;
                            active_next = 1'b0;
                        end
                        else if (tok_in.level <= rbpto_pkg::LEVEL_PWM_MAX)
                        begin
                            mode_next = rbpto_pkg::PWM_BASE
                                      + rbpto_pkg::MODE_W'(tok_in.level);
                        end
                        else if (tok_in.level == rbpto_pkg::LEVEL_FULL)
                        begin
                            mode_next   = rbpto_pkg::MODE_ON;
                            active_next = 1'b1;
                        end
                    end
                end
                rbpto_pkg::ACT_DELAYED:
                begin
                    if (hit && tok_in.delay_ok)
                    begin
                        mode_next   = rbpto_pkg::DELAY_OFFSET + tok_in.delay;
                        active_next = 1'b1;
                    end
                end
                rbpto_pkg::ACT_TENTH:
                begin
                    if (mode_reg == rbpto_pkg::TIMED_BASE)
                    begin
                        mode_next   = rbpto_pkg::MODE_OFF;
                        active_next = 1'b0;
                    end
                    else if (mode_reg > rbpto_pkg::TIMED_BASE)
                    begin
                        mode_next = mode_reg - rbpto_pkg::MODE_ON;
                    end
                end
                rbpto_pkg::ACT_MS:
                begin
                    if (mode_reg >= rbpto_pkg::PWM_BASE && mode_reg < rbpto_pkg::TIMED_BASE)
                    begin
                        if (tok_in.phase == '0)
                        begin
                            active_next = 1'b1;
                        end
                        else if (pwm_offset == rbpto_pkg::MODE_W'(tok_in.phase))
                        begin
                            active_next = 1'b0;
                        end
                    end
                end
                rbpto_pkg::ACT_DEFAULT:
                begin
                    mode_next   = def_on ? rbpto_pkg::MODE_ON : rbpto_pkg::MODE_OFF;
                    active_next = def_on;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign pin      = active_next ? on_level : ~on_level;
    assign is_on    = (mode_next != rbpto_pkg::MODE_OFF);
    assign is_timed = (mode_next > rbpto_pkg::DELAY_OFFSET);

    generate
        if (CELL_IDX < rbpto_pkg::MASK_W)
        begin : g_report
            localparam logic [2:0] BIT = 3'(CELL_IDX);
            always_comb
            begin
                tok_next = tok_in;
                tok_next.acc.pin_levels[BIT]       = tok_in.acc.pin_levels[BIT] | pin;
                tok_next.acc.on_mask[BIT]          = tok_in.acc.on_mask[BIT] | is_on;
                tok_next.acc.delayed_off_mask[BIT] = tok_in.acc.delayed_off_mask[BIT]
                                                   | is_timed;
            end
        end
        else
        begin : g_silent
            // relays past the reported width still hold state but add no bits
            always_comb
            begin
                tok_next = tok_in;
                tok_next.acc.pin_levels[0] = tok_in.acc.pin_levels[0] | (pin & is_on & 1'b0);
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= rbpto_pkg::MODE_OFF;
            active_reg <= 1'b0;
            tok_reg    <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            active_reg <= active_next;
            tok_reg    <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

FILE: rtl/core/relay_bank_pwm_timed_off.sv
// Path: an accepted command is registered in entry_reg, then passes one register per relay cell
// and is held in res_reg. Each command walks the row of relay cells one cell per cycle; the row
// has RELAY_COUNT cells, capped at SLOT_LIMIT. One command is in flight at a time, so a new
// command is accepted only after the result of the previous one has been taken.
// Reset: all relays off with pins at the inactive level, PWM phase 0,
// on-level mask all ones, default-on mask zero.
`timescale 1ns / 1ps

module relay_bank_pwm_timed_off #(
    parameter int RELAY_COUNT = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cmd_valid,
    output logic                                 cmd_ready,
    input  rbpto_pkg::cmd_t                      cmd,
    output logic                                 res_valid,
    input  logic                                 res_ready,
    output rbpto_pkg::res_t                      res,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rbpto_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rbpto_pkg::MASK_W-1:0]         cfg_data
);

    localparam int CELLS = (RELAY_COUNT > rbpto_pkg::SLOT_LIMIT) ?
                           rbpto_pkg::SLOT_LIMIT : RELAY_COUNT;

    logic [rbpto_pkg::MASK_W-1:0]  on_level_mask_reg;
    logic [rbpto_pkg::MASK_W-1:0]  default_on_mask_reg;
    logic [rbpto_pkg::PHASE_W-1:0] phase_reg;
    logic [rbpto_pkg::PHASE_W-1:0] phase_next;
    logic                          busy_reg;
    logic                          res_valid_reg;
    rbpto_pkg::res_t               res_reg;
    rbpto_pkg::token_t             entry_reg;
    rbpto_pkg::token_t             entry_next;
    rbpto_pkg::token_t             chain [CELLS+1];

    logic                          cmd_fire;
    logic                          num_ok;
    logic [rbpto_pkg::PCT_W:0]     pct_biased;
    logic [16:0]                   pct_prod;

    assign cmd_ready = ~busy_reg;
    assign cmd_fire  = cmd_valid & cmd_ready;
    assign cfg_ready = 1'b1;

    assign num_ok = (cmd.relay_number != '0)
                 && (cmd.relay_number <= rbpto_pkg::NUM_W'(CELLS));

    assign pct_biased = {1'b0, cmd.power_percent} + rbpto_pkg::ROUND_BIAS;
    assign pct_prod   = 17'(pct_biased) * 17'(rbpto_pkg::RECIP_MUL);

    always_comb
    begin
        phase_next = phase_reg;
        if (cmd_fire && cmd.action == rbpto_pkg::ACT_MS)
        begin
            phase_next = (phase_reg >= rbpto_pkg::PHASE_LAST) ? '0 : phase_reg + 4'd1;
        end
    end

    always_comb
    begin
        entry_next          = '0;
        entry_next.valid    = cmd_fire;
        entry_next.action   = cmd.action;
        entry_next.hit      = num_ok;
        entry_next.sel      = cmd.relay_number - 4'd1;
        entry_next.level    = pct_prod[rbpto_pkg::RECIP_SHIFT +: rbpto_pkg::LEVEL_W];
        entry_next.delay_ok = (cmd.delay_tenths != '0)
                           && (cmd.delay_tenths <= rbpto_pkg::DELAY_MAX);
        entry_next.delay    = cmd.delay_tenths;
        entry_next.phase    = phase_next;
    end

    assign chain[0] = entry_reg;

    generate
        for (genvar i = 0; i < CELLS; i++)
        begin : g_cell
            logic def_on;
            logic on_level;
            if (i < rbpto_pkg::MASK_W)
            begin : g_cfg
                assign def_on   = default_on_mask_reg[i];
                assign on_level = on_level_mask_reg[i];
            end
            else
            begin : g_fixed
                assign def_on   = 1'b0;
                assign on_level = 1'b1;
            end

            rbpto_cell #(
                .CELL_IDX (i)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .tok_in   (chain[i]),
                .def_on   (def_on),
                .on_level (on_level),
                .tok_out  (chain[i+1])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_level_mask_reg   <= '1;
            default_on_mask_reg <= '0;
            phase_reg           <= '0;
            busy_reg            <= 1'b0;
            res_valid_reg       <= 1'b0;
            entry_reg           <= '0;
            res_reg             <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    rbpto_pkg::CFG_ON_LEVEL:   on_level_mask_reg   <= cfg_data;
                    rbpto_pkg::CFG_DEFAULT_ON: default_on_mask_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end

            phase_reg <= phase_next;
            entry_reg <= entry_next;

            // hold a finished result until taken, then free the chain
            if (chain[CELLS].valid)
            begin
                res_valid_reg <= 1'b1;
                res_reg       <= chain[CELLS].acc;
            end
            else if (res_valid_reg && res_ready)
            begin
                res_valid_reg <= 1'b0;
            end

            if (cmd_fire)
            begin
                busy_reg <= 1'b1;
            end
            else if (res_valid_reg && res_ready)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

FILE: tb/relay_bank_pwm_timed_off_tb.sv
`timescale 1ns / 1ps

module relay_bank_pwm_timed_off_tb;

    localparam int NCH          = 8;
    localparam int LATENCY      = NCH + 2;
    localparam int STALL_CYCLES = 400;

    localparam logic [rbpto_pkg::ACTION_W-1:0]  ACT_NONE     = 3'd7;
    localparam logic [rbpto_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [rbpto_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            cmd_valid = 1'b0;
    logic                            cmd_ready;
    rbpto_pkg::cmd_t                 cmd       = '0;
    logic                            res_valid;
    logic                            res_ready = 1'b0;
    rbpto_pkg::res_t                 res;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [rbpto_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [rbpto_pkg::MASK_W-1:0]    cfg_data  = '0;

    logic [rbpto_pkg::MODE_W-1:0]  chan_mode [NCH];
    logic                          chan_live [NCH];
    logic [rbpto_pkg::PHASE_W-1:0] pwm_step;
    logic [rbpto_pkg::MASK_W-1:0]  lvl_mask;
    logic [rbpto_pkg::MASK_W-1:0]  dflt_mask;

    rbpto_pkg::res_t due_status [$];
    rbpto_pkg::res_t want;
    int              errors    = 0;
    bit              steady    = 1'b0;
    bit              stall_req = 1'b0;

    relay_bank_pwm_timed_off #(
        .RELAY_COUNT(NCH)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endtask

    task automatic clear_bank();
        int k;
        for (k = 0; k < NCH; k++)
        begin
            chan_mode[k] = rbpto_pkg::MODE_OFF;
            chan_live[k] = 1'b0;
        end
        pwm_step  = '0;
        lvl_mask  = 8'hFF;
        dflt_mask = 8'h00;
    endtask

    function automatic rbpto_pkg::res_t step_bank(input rbpto_pkg::cmd_t c);
        rbpto_pkg::res_t r;
        int              k;
        int              sel;
        int              lvl;
        bit              hit;
        hit = (c.relay_number >= 1) && (c.relay_number <= NCH);
        sel = hit ? int'(c.relay_number) - 1 : 0;
        lvl = (int'(c.power_percent) + 5) / 10;
        case (c.action)
            rbpto_pkg::ACT_ON:
                if (hit)
                begin
                    chan_mode[sel] = rbpto_pkg::MODE_ON;
                    chan_live[sel] = 1'b1;
                end
            rbpto_pkg::ACT_OFF:
                if (hit)
                begin
                    chan_mode[sel] = rbpto_pkg::MODE_OFF;
                    chan_live[sel] = 1'b0;
                end
            rbpto_pkg::ACT_POWER:
                if (hit)
                begin
                    if (lvl == 0)
                    begin
                        chan_mode[sel] = rbpto_pkg::MODE_OFF;
                        chan_live[sel] = 1'b0;
                    end
                    else if (lvl <= int'(rbpto_pkg::LEVEL_PWM_MAX))
                        chan_mode[sel] = rbpto_pkg::PWM_BASE + rbpto_pkg::MODE_W'(lvl);
                    else if (lvl == int'(rbpto_pkg::LEVEL_FULL))
                    begin
                        chan_mode[sel] = rbpto_pkg::MODE_ON;
                        chan_live[sel] = 1'b1;
                    end
                end
            rbpto_pkg::ACT_DELAYED:
                if (hit && c.delay_tenths >= 1 && c.delay_tenths <= rbpto_pkg::DELAY_MAX)
                begin
                    chan_mode[sel] = rbpto_pkg::DELAY_OFFSET + c.delay_tenths;
                    chan_live[sel] = 1'b1;
                end
            rbpto_pkg::ACT_TENTH:
                for (k = 0; k < NCH; k++)
                begin
                    if (chan_mode[k] >= rbpto_pkg::TIMED_BASE)
                    begin
                        chan_mode[k] = chan_mode[k] - rbpto_pkg::MODE_W'(1);
                        if (chan_mode[k] < rbpto_pkg::TIMED_BASE)
                        begin
                            chan_mode[k] = rbpto_pkg::MODE_OFF;
                            chan_live[k] = 1'b0;
                        end
                    end
                end
            rbpto_pkg::ACT_MS:
            begin
                pwm_step = (pwm_step == rbpto_pkg::PHASE_LAST) ? '0
                                                               : pwm_step + 4'd1;
                for (k = 0; k < NCH; k++)
                begin
                    if (chan_mode[k] >= rbpto_pkg::PWM_BASE
                        && chan_mode[k] < rbpto_pkg::TIMED_BASE)
                    begin
                        if (pwm_step == 0)
                            chan_live[k] = 1'b1;
                        else if (chan_mode[k] - rbpto_pkg::PWM_BASE
                                 == rbpto_pkg::MODE_W'(pwm_step))
                            chan_live[k] = 1'b0;
                    end
                end
            end
            rbpto_pkg::ACT_DEFAULT:
                for (k = 0; k < NCH; k++)
                begin
                    chan_mode[k] = dflt_mask[k] ? rbpto_pkg::MODE_ON : rbpto_pkg::MODE_OFF;
                    chan_live[k] = dflt_mask[k];
                end
            default: ;
        endcase
        r = '0;
        for (k = 0; k < NCH; k++)
        begin
            r.pin_levels[k]       = chan_live[k] ? lvl_mask[k] : ~lvl_mask[k];
            r.on_mask[k]          = (chan_mode[k] != rbpto_pkg::MODE_OFF);
            r.delayed_off_mask[k] = (chan_mode[k] > rbpto_pkg::DELAY_OFFSET);
        end
        return r;
    endfunction

    function automatic rbpto_pkg::cmd_t cmd_of(input logic [rbpto_pkg::ACTION_W-1:0] act,
                                               input logic [rbpto_pkg::NUM_W-1:0] num,
                                               input logic [rbpto_pkg::PCT_W-1:0] pct,
                                               input logic [rbpto_pkg::DELAY_W-1:0] dly);
        rbpto_pkg::cmd_t c;
        c.action        = act;
        c.relay_number  = num;
        c.power_percent = pct;
        c.delay_tenths  = dly;
        return c;
    endfunction

    function automatic rbpto_pkg::cmd_t random_cmd();
        rbpto_pkg::cmd_t c;
        int              pick;
        c.action        = rbpto_pkg::ACTION_W'($urandom_range(7));
        c.relay_number  = ($urandom_range(9) == 0) ? rbpto_pkg::NUM_W'($urandom_range(15))
                                                   : rbpto_pkg::NUM_W'($urandom_range(1, NCH));
        c.power_percent = ($urandom_range(9) < 7) ? rbpto_pkg::PCT_W'($urandom_range(104))
                                                  : rbpto_pkg::PCT_W'($urandom_range(255));
        c.delay_tenths  = ($urandom_range(3) != 0) ? rbpto_pkg::DELAY_W'($urandom_range(1, 40))
                                                   : rbpto_pkg::DELAY_W'($urandom_range(65535));
        pick = $urandom_range(99);
        if (pick < 30)
            c.action = rbpto_pkg::ACT_MS;
        else if (pick < 42)
            c.action = rbpto_pkg::ACT_TENTH;
        else if (pick < 52)
            c.action = rbpto_pkg::ACT_ON;
        else if (pick < 60)
            c.action = rbpto_pkg::ACT_OFF;
        else if (pick < 75)
            c.action = rbpto_pkg::ACT_POWER;
        else if (pick < 88)
            c.action = rbpto_pkg::ACT_DELAYED;
        else if (pick < 92)
            c.action = rbpto_pkg::ACT_DEFAULT;
        return c;
    endfunction

    task automatic send_cmd(input rbpto_pkg::cmd_t c);
        while (!steady && $urandom_range(99) < 25)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        do @(posedge clk); while (!cmd_ready);
        due_status.push_back(step_bank(c));
    endtask

    task automatic write_reg(input logic [rbpto_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rbpto_pkg::MASK_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == rbpto_pkg::CFG_ON_LEVEL)
            lvl_mask = val;
        else if (idx == rbpto_pkg::CFG_DEFAULT_ON)
            dflt_mask = val;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic settle();
        cmd_valid <= 1'b0;
        do @(posedge clk); while (due_status.size() != 0);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic test_reset_state();
        send_cmd(cmd_of(ACT_NONE, 4'd1, 8'hFF, 16'hFFFF));
        send_cmd(cmd_of(rbpto_pkg::ACT_OFF, 4'd0, 8'h00, 16'h0000));
    endtask

    task automatic test_switching();
        send_cmd(cmd_of(rbpto_pkg::ACT_ON, 4'd1, 8'd0, 16'd0));
        send_cmd(cmd_of(rbpto_pkg::ACT_ON, 4'd8, 8'd0, 16'd0));
        send_cmd(cmd_of(rbpto_pkg::ACT_OFF, 4'd1, 8'd0, 16'd0));
        send_cmd(cmd_of(rbpto_pkg::ACT_ON, 4'd0, 8'd0, 16'd0));
        send_cmd(cmd_of(rbpto_pkg::ACT_ON, 4'd9, 8'd0, 16'd0));
        send_cmd(cmd_of(rbpto_pkg::ACT_ON, 4'd15, 8'd0, 16'd0));
        send_cmd(cmd_of(rbpto_pkg::ACT_OFF, 4'd15, 8'd0, 16'd0));
        send_cmd(cmd_of(ACT_NONE, 4'd8, 8'd50, 16'd100));
    endtask

    task automatic test_power_levels();
        send_cmd(cmd_of(rbpto_pkg::ACT_POWER, 4'd2, 8'd0, 16'd0));
        send_cmd(cmd_of(rbpto_pkg::ACT_POWER, 4'd2, 8'd4, 16'd0));
        send_cmd(cmd_of(rbpto_pkg::ACT_POWER, 4'd2, 8'd5, 16'd0));
        send_cmd(cmd_of(rbpto_pkg::ACT_POWER, 4'd2, 8'd94, 16'd0));
        send_cmd(cmd_of(rbpto_pkg::ACT_POWER, 4'd2, 8'd95, 16'd0));
        send_cmd(cmd_of(rbpto_pkg::ACT_POWER, 4'd2, 8'd104, 16'd0));
        send_cmd(cmd_of(rbpto_pkg::ACT_POWER, 4'd2, 8'd105, 16'd0));
        send_cmd(cmd_of(rbpto_pkg::ACT_POWER, 4'd2, 8'd255, 16'd0));
    endtask

    task automatic test_timed_off();
        send_cmd(cmd_of(rbpto_pkg::ACT_DELAYED, 4'd3, 8'd0, 16'd0));
        send_cmd(cmd_of(rbpto_pkg::ACT_DELAYED, 4'd3, 8'd0, 16'hFFFF));
        send_cmd(cmd_of(rbpto_pkg::ACT_DELAYED, 4'd3, 8'd0, rbpto_pkg::DELAY_MAX));
        send_cmd(cmd_of(rbpto_pkg::ACT_DELAYED, 4'd4, 8'd0, 16'd1));
        send_cmd(cmd_of(rbpto_pkg::ACT_TENTH, 4'd0, 8'd0, 16'd0));
    endtask

    task automatic test_register_writes();
        settle();
        write_reg(CFG_SPARE_LO, 8'h00);
        write_reg(CFG_SPARE_HI, 8'hFF);
        send_cmd(cmd_of(rbpto_pkg::ACT_DEFAULT, 4'd0, 8'd0, 16'd0));
        settle();
        write_reg(rbpto_pkg::CFG_ON_LEVEL, 8'h0F);
        write_reg(rbpto_pkg::CFG_DEFAULT_ON, 8'hF0);
        send_cmd(cmd_of(rbpto_pkg::ACT_DEFAULT, 4'd0, 8'd0, 16'd0));
        send_cmd(cmd_of(ACT_NONE, 4'd0, 8'd0, 16'd0));
    endtask

    task automatic test_pwm_sweep();
        int k;
        for (k = 1; k <= NCH; k++)
            send_cmd(cmd_of(rbpto_pkg::ACT_POWER, rbpto_pkg::NUM_W'(k),
                            rbpto_pkg::PCT_W'(k * 10 + $urandom_range(9) - 4),
                            rbpto_pkg::DELAY_W'($urandom)));
        for (k = 0; k < 40; k++)
            send_cmd(($urandom_range(4) == 0) ? random_cmd()
                                              : cmd_of(rbpto_pkg::ACT_MS,
                                                       rbpto_pkg::NUM_W'($urandom),
                                                       rbpto_pkg::PCT_W'($urandom),
                                                       rbpto_pkg::DELAY_W'($urandom)));
    endtask

    task automatic test_random_traffic(input int n, input logic [rbpto_pkg::MASK_W-1:0] lvl,
                                       input logic [rbpto_pkg::MASK_W-1:0] dflt,
                                       input bit quiet);
        int k;
        settle();
        write_reg(rbpto_pkg::CFG_ON_LEVEL, lvl);
        write_reg(rbpto_pkg::CFG_DEFAULT_ON, dflt);
        steady = quiet;
        for (k = 0; k < n; k++)
            send_cmd(random_cmd());
        steady = 1'b0;
    endtask

    task automatic test_backpressure();
        int k;
        steady    = 1'b1;
        stall_req = 1'b1;
        for (k = 0; k < 40; k++)
            send_cmd(random_cmd());
        steady = 1'b0;
    endtask

    // hold off the result side for a long stretch on request, else take results at random (always when steady)
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (stall_req)
            begin
                stall_req = 1'b0;
                res_ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge clk);
            end
            res_ready <= steady || ($urandom_range(99) >= 25);
        end
    end

    always @(posedge clk)
    begin
        if (res_valid === 1'b1 && res_ready)
        begin
            if (due_status.size() == 0)
                report_error("result transaction with no command pending");
            else
            begin
                want = due_status.pop_front();
                if (res.pin_levels !== want.pin_levels)
                    report_error($sformatf("pin_levels %h, want %h",
                                           res.pin_levels, want.pin_levels));
                if (res.on_mask !== want.on_mask)
                    report_error($sformatf("on_mask %h, want %h",
                                           res.on_mask, want.on_mask));
                if (res.delayed_off_mask !== want.delayed_off_mask)
                    report_error($sformatf("delayed_off_mask %h, want %h",
                                           res.delayed_off_mask, want.delayed_off_mask));
            end
        end
    end

    initial
    begin
        clear_bank();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_switching();
        test_power_levels();
        test_timed_off();
        test_register_writes();
        test_pwm_sweep();
        test_random_traffic(210, 8'hFF, 8'h00, 1'b0);
        test_random_traffic(210, 8'h00, 8'hFF, 1'b0);
        test_random_traffic(210, 8'hA5, 8'h3C, 1'b1);
        test_backpressure();
        test_random_traffic(210, rbpto_pkg::MASK_W'($urandom),
                            rbpto_pkg::MASK_W'($urandom), 1'b0);
        test_random_traffic(210, rbpto_pkg::MASK_W'($urandom),
                            rbpto_pkg::MASK_W'($urandom), 1'b0);
        settle();
        if (errors == 0)
            $display("relay_bank_pwm_timed_off_tb: clean");
        else
            $display("relay_bank_pwm_timed_off_tb: errors");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("relay_bank_pwm_timed_off_tb: errors");
        $finish;
    end

endmodule
